// ----- src/mte_pkg.sv -----
// shared types, constants and helpers of the midi track event encoder
// no dependencies
`timescale 1ns / 1ps

package mte_pkg;

  localparam int TICK_BITS   = 28;
  localparam int TPQ_W       = 15;
  localparam int BPM_W       = 16;
  localparam int DUR_W       = 32;
  localparam int DIV_W       = TPQ_W + DUR_W;
  localparam int DVS_W       = 24;
  localparam int STEP_W      = $clog2(DIV_W + 1);
  localparam int VAL_W       = (TICK_BITS > DVS_W) ? TICK_BITS : DVS_W;
  localparam int VLQ_GROUPS  = (TICK_BITS + 6) / 7;
  localparam int VLQ_W       = VLQ_GROUPS * 7;
  localparam int IDX_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TPQ_W-1:0] TPQ_RESET = TPQ_W'(240);
  localparam logic [BPM_W-1:0] BPM_RESET = BPM_W'(120);
  localparam logic [BPM_W-1:0] BPM_MIN   = BPM_W'(4);
  localparam int US_PER_MIN = 60000000;
  localparam int UPQ_STEPS  = 26;

  // divide by three as multiply and shift, exact for any 15-bit value
  localparam int          DIV3_SHIFT = 17;
  localparam int          DIV3_W     = TPQ_W + 16;
  localparam logic [15:0] DIV3_RECIP = 16'd43691;

  localparam logic [7:0] DELTA_ZERO  = 8'h00;
  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam logic [7:0] NOTE_OFF    = 8'h80;
  localparam logic [7:0] META        = 8'hff;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TSIG   = 8'h58;
  localparam logic [7:0] META_EOT    = 8'h2f;
  localparam logic [7:0] LEN_TEMPO   = 8'h03;
  localparam logic [7:0] LEN_TSIG    = 8'h04;
  localparam logic [7:0] LEN_EOT     = 8'h00;
  localparam logic [7:0] RELEASE_VEL = 8'd64;
  localparam logic [7:0] VLQ_MORE    = 8'h80;
  localparam logic [7:0] TSIG_32ND   = 8'd8;

  typedef enum logic [1:0] {
    FUNC_NOTE  = 2'd0,
    FUNC_TEMPO = 2'd1,
    FUNC_TSIG  = 2'd2,
    FUNC_EOT   = 2'd3
  } func_t;

  typedef enum logic {
    REG_TPQ = 1'b0,
    REG_BPM = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    func_t            kind;
    logic [3:0]       channel;
    logic [6:0]       key;
    logic [6:0]       velocity;
    logic [VAL_W-1:0] value;
    logic [7:0]       beats;
    logic [2:0]       lg;
    logic [7:0]       clocks;
  } event_t;

  // number of 7-bit groups in the variable-length tick delta
  function automatic logic [2:0] vlq_len(input logic [VLQ_W-1:0] v);
    logic [2:0] n;
    n = 3'd1;
    for (int g = 1; g < VLQ_GROUPS; g++) begin
      if ((v >> (7 * g)) != '0) n = 3'(g + 1);
    end
    return n;
  endfunction

endpackage

// ----- src/mte_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on mte_pkg
`timescale 1ns / 1ps

module mte_div (
  input  logic              clk,
  input  logic              rst,
  input  mte_pkg::div_req_t req,
  output mte_pkg::div_rsp_t rsp
);
  import mte_pkg::*;

  logic [DIV_W-1:0]  q;
  logic [DIV_W-1:0]  q_next;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  rem_next;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic              done;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  diff;

  always_comb begin
    rem_sh = {rem, q[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    if (!diff[DVS_W+1]) begin
      rem_next = diff[DVS_W-1:0];
      q_next   = {q[DIV_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[DVS_W-1:0];
      q_next   = {q[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == STEP_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
      cnt <= req.steps;
    end else if (run) begin
      q   <= q_next;
      rem <= rem_next;
      cnt <= cnt - STEP_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = q;

endmodule

// ----- src/mte_front.sv -----
// front end: takes a request, classifies it and works out its numbers
// depends on mte_pkg and mte_div
`timescale 1ns / 1ps

module mte_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  func,
  input  logic [3:0]                  channel,
  input  logic [6:0]                  key,
  input  logic [6:0]                  velocity,
  input  logic [mte_pkg::DUR_W-1:0]   duration_us,
  input  logic [7:0]                  beats,
  input  logic [7:0]                  beat_unit,
  input  logic [mte_pkg::TPQ_W-1:0]   tpq,
  input  logic [mte_pkg::BPM_W-1:0]   bpm,
  input  logic                        full,
  output logic                        busy,
  output logic                        push,
  output mte_pkg::event_t             ev
);
  import mte_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t           state;
  fstate_t           state_next;
  event_t            ev_r;
  logic [DIV_W-1:0]  prod;
  logic              div_ticks;
  div_req_t          req;
  div_rsp_t          rsp;
  logic [2:0]        lg;
  logic              unit_ok;
  logic [BPM_W-1:0]  bpm_eff;
  func_t             fin;
  logic [DIV3_W-1:0] tpq_div3;

  mte_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign fin      = func_t'(func);
  assign bpm_eff  = (bpm < BPM_MIN) ? BPM_MIN : bpm;
  assign tpq_div3 = DIV3_W'(tpq) * DIV3_W'(DIV3_RECIP);

  always_comb begin
    lg      = 3'd0;
    unit_ok = 1'b1;
    case (beat_unit)
      8'd1:    lg = 3'd0;
      8'd2:    lg = 3'd1;
      8'd4:    lg = 3'd2;
      8'd8:    lg = 3'd3;
      8'd16:   lg = 3'd4;
      8'd32:   lg = 3'd5;
      default: unit_ok = 1'b0;
    endcase
  end

  // divider requests: tempo period, then tick count
  always_comb begin
    req = '0;
    if (state == F_IDLE && start) begin
      case (fin)
        FUNC_NOTE, FUNC_TEMPO: begin
          req.start    = 1'b1;
          req.dividend = DIV_W'(US_PER_MIN) << (DIV_W - UPQ_STEPS);
          req.divisor  = DVS_W'(bpm_eff);
          req.steps    = STEP_W'(UPQ_STEPS);
        end
        default: req = '0;
      endcase
    end else if (state == F_DIV && rsp.done && ev_r.kind == FUNC_NOTE && !div_ticks) begin
      req.start    = 1'b1;
      req.dividend = prod;
      req.divisor  = rsp.quotient[DVS_W-1:0];
      req.steps    = STEP_W'(DIV_W);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (start) begin
          case (fin)
            FUNC_NOTE, FUNC_TEMPO: state_next = F_DIV;
            FUNC_TSIG: begin
              if (!unit_ok) state_next = F_IDLE;
              else          state_next = F_PUSH;
            end
            default: state_next = F_PUSH;
          endcase
        end
      end
      F_DIV: begin
        if (rsp.done && !(ev_r.kind == FUNC_NOTE && !div_ticks)) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      div_ticks <= 1'b0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) div_ticks <= 1'b0;
      else if (state == F_DIV && rsp.done && ev_r.kind == FUNC_NOTE) div_ticks <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      ev_r.kind     <= fin;
      ev_r.channel  <= channel;
      ev_r.key      <= key;
      ev_r.velocity <= velocity;
      ev_r.value    <= '0;
      ev_r.beats    <= beats;
      ev_r.lg       <= lg;
      // clocks per click: a third of the divisions for eighth-note beats
      ev_r.clocks   <= (lg == 3'd3) ? tpq_div3[DIV3_SHIFT +: 8] : tpq[7:0];
      prod          <= DIV_W'(tpq) * DIV_W'(duration_us);
    end else if (state == F_DIV && rsp.done) begin
      case (ev_r.kind)
        FUNC_NOTE: begin
          if (div_ticks) begin
            if (|rsp.quotient[DIV_W-1:TICK_BITS]) ev_r.value <= VAL_W'({TICK_BITS{1'b1}});
            else ev_r.value <= VAL_W'(rsp.quotient[TICK_BITS-1:0]);
          end
        end
        FUNC_TEMPO: ev_r.value <= VAL_W'(rsp.quotient[DVS_W-1:0]);
        default:    ev_r.value <= ev_r.value;
      endcase
    end
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !full;
  assign ev   = ev_r;

endmodule

// ----- src/mte_queue.sv -----
// short queue of classified events between front and back end
// depends on mte_pkg
`timescale 1ns / 1ps

module mte_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mte_pkg::event_t din,
  input  logic            pop,
  output mte_pkg::event_t head,
  output logic            full,
  output logic            empty
);
  import mte_pkg::*;

  event_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + QPTR_W'(1);
      if (pop)  rp <= (rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign head  = mem[rp];
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

endmodule

// ----- src/mte_back.sv -----
// back end: serializes one event into track bytes, one per cycle
// depends on mte_pkg
`timescale 1ns / 1ps

module mte_back (
  input  logic            clk,
  input  logic            rst,
  input  mte_pkg::event_t head,
  input  logic            empty,
  output logic            pop,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            strobe
);
  import mte_pkg::*;

  event_t           cur;
  logic             active;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] len;
  logic [IDX_W-1:0] g;
  logic [IDX_W-1:0] j;
  logic [2:0]       vn;
  logic [2:0]       s;
  logic [VLQ_W-1:0] vlq_v;
  logic [6:0]       grp;
  logic [7:0]       byte_next;
  logic             at_end;

  assign vlq_v = VLQ_W'(cur.value[TICK_BITS-1:0]);
  assign vn    = vlq_len(vlq_v);
  assign g     = idx - IDX_W'(4);
  assign j     = g - IDX_W'(vn);
  assign s     = vn - 3'd1 - g[2:0];

  always_comb begin
    grp = '0;
    for (int i = 0; i < VLQ_GROUPS; i++) begin
      if (s == 3'(i)) grp = vlq_v[7*i +: 7];
    end
  end

  always_comb begin
    case (cur.kind)
      FUNC_NOTE:  len = IDX_W'(7) + IDX_W'(vn);
      FUNC_TEMPO: len = IDX_W'(7);
      FUNC_TSIG:  len = IDX_W'(8);
      default:    len = IDX_W'(4);
    endcase
  end

  always_comb begin
    byte_next = DELTA_ZERO;
    case (cur.kind)
      FUNC_NOTE: begin
        if (idx < IDX_W'(4)) begin
          case (idx[1:0])
            2'd0:    byte_next = DELTA_ZERO;
            2'd1:    byte_next = NOTE_ON | {4'h0, cur.channel};
            2'd2:    byte_next = {1'b0, cur.key};
            default: byte_next = {1'b0, cur.velocity};
          endcase
        end else if (g < IDX_W'(vn)) begin
          byte_next = {1'b0, grp} | ((s != 3'd0) ? VLQ_MORE : 8'h00);
        end else begin
          case (j)
            IDX_W'(0): byte_next = NOTE_OFF | {4'h0, cur.channel};
            IDX_W'(1): byte_next = {1'b0, cur.key};
            default:   byte_next = RELEASE_VEL;
          endcase
        end
      end
      FUNC_TEMPO: begin
        case (idx)
          IDX_W'(0): byte_next = DELTA_ZERO;
          IDX_W'(1): byte_next = META;
          IDX_W'(2): byte_next = META_TEMPO;
          IDX_W'(3): byte_next = LEN_TEMPO;
          IDX_W'(4): byte_next = cur.value[23:16];
          IDX_W'(5): byte_next = cur.value[15:8];
          default:   byte_next = cur.value[7:0];
        endcase
      end
      FUNC_TSIG: begin
        case (idx)
          IDX_W'(0): byte_next = DELTA_ZERO;
          IDX_W'(1): byte_next = META;
          IDX_W'(2): byte_next = META_TSIG;
          IDX_W'(3): byte_next = LEN_TSIG;
          IDX_W'(4): byte_next = cur.beats;
          IDX_W'(5): byte_next = {5'b0, cur.lg};
          IDX_W'(6): byte_next = cur.clocks;
          default:   byte_next = TSIG_32ND;
        endcase
      end
      default: begin
        case (idx)
          IDX_W'(0): byte_next = DELTA_ZERO;
          IDX_W'(1): byte_next = META;
          IDX_W'(2): byte_next = META_EOT;
          default:   byte_next = LEN_EOT;
        endcase
      end
    endcase
  end

  assign at_end = (idx == len - IDX_W'(1));
  assign pop    = !active && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      idx    <= '0;
    end else begin
      strobe <= 1'b0;
      if (active) begin
        strobe <= 1'b1;
        idx    <= idx + IDX_W'(1);
        if (at_end) active <= 1'b0;
      end else if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (active) begin
      out_byte <= byte_next;
      last     <= at_end;
    end
  end

endmodule

// ----- src/midi_track_event_encoder.sv -----
// top level of the midi track event encoder: config registers, front, queue, back
// depends on mte_pkg, mte_front, mte_queue, mte_back
`timescale 1ns / 1ps

// One request (start high while busy is low) becomes the bytes of one track
// event, sent one byte per cycle on out_byte with strobe high for exactly that
// cycle and last high on the final byte; the receiver cannot hold bytes off.
// A note keeps the front end busy for two runs of the one-bit-per-cycle
// divider, a 26-bit quotient for the tempo period and then a 47-bit one for
// the tick count, chained before the event goes to the queue. A tempo
// request needs only the first division; time signature and end-of-track
// requests need none (the clocks byte for beat unit 8 is a multiply by the
// reciprocal of three). A time signature with an unsupported beat unit
// never raises busy; it is accepted and sends nothing. A two-entry
// event queue sits between the front end and the byte sequencer, so requests
// are accepted while earlier events are still being sent; when the queue is
// full the front end holds its event and stays busy until an entry frees up.
// The sequencer takes an event into cur, then sends it through the registered
// out_byte and strobe; no byte goes out in the cycle after a final byte.
// Configuration: wr_en with wr_index 0 writes ticks_per_quarter, index 1
// writes tempo_bpm; write only while no event is pending.

module midi_track_event_encoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic [3:0]                channel,
  input  logic [6:0]                key,
  input  logic [6:0]                velocity,
  input  logic [mte_pkg::DUR_W-1:0] duration_us,
  input  logic [7:0]                beats,
  input  logic [7:0]                beat_unit,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [mte_pkg::BPM_W-1:0] wr_data,
  output logic [7:0]                out_byte,
  output logic                      last,
  output logic                      strobe
);
  import mte_pkg::*;

  logic [TPQ_W-1:0] tpq;
  logic [BPM_W-1:0] bpm;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  event_t           ev;
  event_t           head;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpq <= TPQ_RESET;
      bpm <= BPM_RESET;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_TPQ: tpq <= wr_data[TPQ_W-1:0];
        REG_BPM: bpm <= wr_data;
        default: bpm <= bpm;
      endcase
    end
  end

  // front end: request capture, classification, divider work
  mte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .channel     (channel),
    .key         (key),
    .velocity    (velocity),
    .duration_us (duration_us),
    .beats       (beats),
    .beat_unit   (beat_unit),
    .tpq         (tpq),
    .bpm         (bpm),
    .full        (full),
    .busy        (busy),
    .push        (push),
    .ev          (ev)
  );

  // finished events waiting for the byte sequencer
  mte_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (ev),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  // byte sequencer
  mte_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .strobe   (strobe)
  );

  // the queue is never written when it has no room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("event queue written while full");

  // a note request always keeps the front end busy while it divides
  a_note_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_NOTE) |=> busy)
    else $error("note request did not start the divider");

  // a popped event sets active, and its first byte then raises the registered strobe
  a_pop_sends: assert property (@(posedge clk) disable iff (rst) pop |-> ##2 strobe)
    else $error("popped event produced no byte");

  // no byte is sent straight after the final byte of an event
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("byte sent right after the final byte");

endmodule

// ----- sim/mte_event_checker.sv -----
// byte-stream checker for the midi track event encoder: predicts and compares
// depends on mte_pkg
`timescale 1ns / 1ps

module mte_event_checker
  import mte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           func,
  input  logic [3:0]           channel,
  input  logic [6:0]           key,
  input  logic [6:0]           velocity,
  input  logic [DUR_W-1:0]     duration_us,
  input  logic [7:0]           beats,
  input  logic [7:0]           beat_unit,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [BPM_W-1:0]     wr_data,
  input  logic [7:0]           out_byte,
  input  logic                 last,
  input  logic                 strobe,
  output int                   mismatches,
  output int                   bytes_due
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } track_byte_t;

  localparam logic [63:0] TICK_MAX = (64'd1 << TICK_BITS) - 64'd1;

  track_byte_t       due_bytes[$];
  logic [TPQ_W-1:0]  tpq_q;
  logic [BPM_W-1:0]  bpm_q;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [31:0] quarter_us();
    logic [BPM_W-1:0] bpm_eff;
    bpm_eff = (bpm_q < BPM_MIN) ? BPM_MIN : bpm_q;
    return 32'(US_PER_MIN) / 32'(bpm_eff);
  endfunction

  // works out the whole byte stream of one track event
  task automatic encode_event(input func_t kind, input logic [3:0] ch, input logic [6:0] k,
                              input logic [6:0] vel, input logic [31:0] dur,
                              input logic [7:0] num, input logic [7:0] unit);
    logic [7:0]  seq[$];
    logic [63:0] ticks;
    logic [31:0] upq;
    logic [31:0] v;
    logic [7:0]  lg;
    logic [14:0] clocks;
    int          shift;
    track_byte_t tb;
    upq = quarter_us();
    case (kind)
      FUNC_NOTE: begin
        ticks = (64'(tpq_q) * 64'(dur)) / 64'(upq);
        if (ticks > TICK_MAX) ticks = TICK_MAX;
        v = ticks[31:0];
        seq.push_back(DELTA_ZERO);
        seq.push_back(NOTE_ON | 8'(ch));
        seq.push_back(8'(k));
        seq.push_back(8'(vel));
        shift = 0;
        while (shift < 28 && (v >> (shift + 7)) != 32'd0) shift += 7;
        for (int s = shift; s > 0; s -= 7) seq.push_back(8'((v >> s) & 32'h7f) | VLQ_MORE);
        seq.push_back(8'(v & 32'h7f));
        seq.push_back(NOTE_OFF | 8'(ch));
        seq.push_back(8'(k));
        seq.push_back(RELEASE_VEL);
      end
      FUNC_TEMPO: begin
        seq.push_back(DELTA_ZERO);
        seq.push_back(META);
        seq.push_back(META_TEMPO);
        seq.push_back(LEN_TEMPO);
        seq.push_back(upq[23:16]);
        seq.push_back(upq[15:8]);
        seq.push_back(upq[7:0]);
      end
      FUNC_TSIG: begin
        lg = 8'hff;
        case (unit)
          8'd1:  lg = 8'd0;
          8'd2:  lg = 8'd1;
          8'd4:  lg = 8'd2;
          8'd8:  lg = 8'd3;
          8'd16: lg = 8'd4;
          8'd32: lg = 8'd5;
          default: lg = 8'hff;
        endcase
        // unsupported denominators send nothing at all
        if (lg != 8'hff) begin
          clocks = (lg == 8'd3) ? tpq_q / 15'd3 : tpq_q;
          seq.push_back(DELTA_ZERO);
          seq.push_back(META);
          seq.push_back(META_TSIG);
          seq.push_back(LEN_TSIG);
          seq.push_back(num);
          seq.push_back(lg);
          seq.push_back(clocks[7:0]);
          seq.push_back(TSIG_32ND);
        end
      end
      default: begin
        seq.push_back(DELTA_ZERO);
        seq.push_back(META);
        seq.push_back(META_EOT);
        seq.push_back(LEN_EOT);
      end
    endcase
    for (int i = 0; i < seq.size(); i++) begin
      tb.data = seq[i];
      tb.is_last = (i == seq.size() - 1);
      due_bytes.push_back(tb);
    end
  endtask

  always @(posedge clk) begin
    track_byte_t want;
    if (rst) begin
      tpq_q = TPQ_RESET;
      bpm_q = BPM_RESET;
      due_bytes.delete();
    end else begin
      if (strobe) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h with nothing expected", out_byte));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (last !== want.is_last)
            report_mismatch($sformatf("last %b, want %b", last, want.is_last));
        end
      end
      if (wr_en) begin
        if (reg_idx_t'(wr_index) == REG_TPQ) tpq_q = wr_data[TPQ_W-1:0];
        else bpm_q = wr_data;
      end
      if (start && !busy)
        encode_event(func_t'(func), channel, key, velocity, duration_us, beats, beat_unit);
    end
    bytes_due = due_bytes.size();
  end

endmodule

// ----- sim/testbench.sv -----
// top of the midi track event encoder testbench: clock, reset, requests, verdict
// depends on mte_pkg, mte_event_checker and the encoder rtl
`timescale 1ns / 1ps

module testbench;
  import mte_pkg::*;

  // settle time after the last expected byte, longer than a note's divisions take
  localparam int SETTLE_CYCLES = 120;
  // worst run is a few hundred requests plus settles
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SEGMENTS      = 6;
  localparam int PER_SEGMENT   = 38;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       func;
  logic [3:0]       channel;
  logic [6:0]       key;
  logic [6:0]       velocity;
  logic [DUR_W-1:0] duration_us;
  logic [7:0]       beats;
  logic [7:0]       beat_unit;
  logic             wr_en;
  logic             wr_index;
  logic [BPM_W-1:0] wr_data;
  logic [7:0]       out_byte;
  logic             last;
  logic             strobe;
  int               mismatches;
  int               bytes_due;
  int               cycle_count;

  midi_track_event_encoder DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .channel     (channel),
    .key         (key),
    .velocity    (velocity),
    .duration_us (duration_us),
    .beats       (beats),
    .beat_unit   (beat_unit),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .out_byte    (out_byte),
    .last        (last),
    .strobe      (strobe)
  );

  mte_event_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .channel     (channel),
    .key         (key),
    .velocity    (velocity),
    .duration_us (duration_us),
    .beats       (beats),
    .beat_unit   (beat_unit),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .out_byte    (out_byte),
    .last        (last),
    .strobe      (strobe),
    .mismatches  (mismatches),
    .bytes_due   (bytes_due)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: a hung encoder ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // present one request and hold it until the encoder takes it;
  // busy only moves at the rising edge, so the falling edge sees what the
  // next rising edge will see; start is left high for a back-to-back request
  task automatic issue_request(input func_t f, input logic [3:0] ch, input logic [6:0] k,
                               input logic [6:0] vel, input logic [31:0] dur,
                               input logic [7:0] num, input logic [7:0] unit);
    start       <= 1'b1;
    func        <= f;
    channel     <= ch;
    key         <= k;
    velocity    <= vel;
    duration_us <= dur;
    beats       <= num;
    beat_unit   <= unit;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // drop start and wait until every expected byte is out and the encoder is quiet;
  // an unsupported time signature sends nothing, so allow a settle time too
  task automatic drain_encoder();
    start <= 1'b0;
    @(negedge clk);
    while (bytes_due != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // config only goes in while idle; both registers back to back
  task automatic apply_settings(input logic [BPM_W-1:0] tpq_word, input logic [BPM_W-1:0] bpm);
    drain_encoder();
    wr_en    <= 1'b1;
    wr_index <= REG_TPQ;
    wr_data  <= tpq_word;
    @(posedge clk);
    wr_index <= REG_BPM;
    wr_data  <= bpm;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  // one random request, mostly notes and supported time signatures
  task automatic send_random_request(input int idle_pct, output bit makes_bytes);
    func_t       f;
    logic [7:0]  unit;
    logic [31:0] dur;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) f = FUNC_NOTE;
    else if (pick < 65) f = FUNC_TEMPO;
    else if (pick < 90) f = FUNC_TSIG;
    else f = FUNC_EOT;
    // mostly legal denominators, the rest anything the byte allows
    if ($urandom_range(0, 9) < 8) unit = 8'd1 << $urandom_range(0, 5);
    else unit = 8'($urandom_range(0, 255));
    // short, musical, full-range and extreme durations
    case ($urandom_range(0, 3))
      0: dur = $urandom_range(0, 1000);
      1: dur = $urandom_range(0, 2000000);
      2: dur = $urandom;
      default: dur = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
    endcase
    makes_bytes = !(f == FUNC_TSIG && !(unit inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32}));
    // sender gap, landing on any phase of the encoder's work
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    issue_request(f, 4'($urandom), 7'($urandom), 7'($urandom), dur,
                  8'($urandom), unit);
  endtask

  initial begin
    logic [BPM_W-1:0] seg_tpq[SEGMENTS];
    logic [BPM_W-1:0] seg_bpm[SEGMENTS];
    int               seg_idle[SEGMENTS];
    int               made;
    bit               makes_bytes;

    rst         <= 1'b1;
    start       <= 1'b0;
    func        <= FUNC_NOTE;
    channel     <= '0;
    key         <= '0;
    velocity    <= '0;
    duration_us <= '0;
    beats       <= '0;
    beat_unit   <= '0;
    wr_en       <= 1'b0;
    wr_index    <= REG_TPQ;
    wr_data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset config: zero and full-range notes, vlq edges, tempo, end of track
    issue_request(FUNC_NOTE, 4'd0, 7'd0, 7'd0, 32'd0, 8'd0, 8'd0);
    issue_request(FUNC_NOTE, 4'd15, 7'd127, 7'd127, 32'hffff_ffff, 8'hff, 8'hff);
    issue_request(FUNC_NOTE, 4'd5, 7'd60, 7'd100, 32'd264584, 8'd0, 8'd4);
    issue_request(FUNC_NOTE, 4'd10, 7'd61, 7'd1, 32'd266667, 8'd0, 8'd4);
    issue_request(FUNC_TEMPO, 4'd0, 7'd0, 7'd0, 32'd0, 8'd0, 8'd0);
    issue_request(FUNC_EOT, 4'd15, 7'd127, 7'd127, 32'hffff_ffff, 8'hff, 8'hff);
    // every supported denominator
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd0, 8'd1);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd255, 8'd2);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd4, 8'd4);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd6, 8'd8);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd3, 8'd16);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd7, 8'd32);
    // unsupported denominators: accepted, nothing sent
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd4, 8'd0);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd4, 8'd3);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd4, 8'd64);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd4, 8'd255);

    // largest divisions at top tempo: tick saturation, wide clock byte
    apply_settings(16'd32767, 16'd65535);
    issue_request(FUNC_NOTE, 4'd3, 7'd64, 7'd90, 32'hffff_ffff, 8'd0, 8'd0);
    issue_request(FUNC_NOTE, 4'd3, 7'd64, 7'd90, 32'd1, 8'd0, 8'd0);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd6, 8'd8);
    issue_request(FUNC_TEMPO, 4'd0, 7'd0, 7'd0, 32'd0, 8'd0, 8'd0);

    // zero divisions and zero tempo, which counts as the lowest tempo
    apply_settings(16'd0, 16'd0);
    issue_request(FUNC_NOTE, 4'd9, 7'd36, 7'd127, 32'hffff_ffff, 8'd0, 8'd0);
    issue_request(FUNC_TEMPO, 4'd0, 7'd0, 7'd0, 32'd0, 8'd0, 8'd0);
    issue_request(FUNC_TSIG, 4'd0, 7'd0, 7'd0, 32'd0, 8'd9, 8'd8);

    // one division per quarter at a tempo just under the floor
    apply_settings(16'd1, 16'd3);
    issue_request(FUNC_TEMPO, 4'd0, 7'd0, 7'd0, 32'd0, 8'd0, 8'd0);
    issue_request(FUNC_NOTE, 4'd1, 7'd72, 7'd50, 32'hffff_ffff, 8'd0, 8'd0);

    // random part: one config per segment, extremes among them;
    // sender idles 13% for two segments, 78% for two, then never
    seg_tpq[0] = 16'd240;   seg_bpm[0] = 16'd120;
    seg_tpq[1] = 16'd1;     seg_bpm[1] = 16'd4;
    seg_tpq[2] = 16'd32767; seg_bpm[2] = 16'd65535;
    seg_tpq[3] = 16'd0;     seg_bpm[3] = 16'd2;
    seg_tpq[4] = 16'd960;   seg_bpm[4] = 16'd1;
    // bit 15 of the divisions word is set here and must be dropped
    seg_tpq[5] = 16'($urandom) | 16'h8000;
    seg_bpm[5] = 16'($urandom);
    for (int s = 0; s < SEGMENTS; s++) seg_idle[s] = (s < 2) ? 13 : (s < 4) ? 78 : 0;

    for (int s = 0; s < SEGMENTS; s++) begin
      apply_settings(seg_tpq[s], seg_bpm[s]);
      made = 0;
      while (made < PER_SEGMENT) begin
        send_random_request(seg_idle[s], makes_bytes);
        if (makes_bytes) made++;
      end
    end

    drain_encoder();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
